/* hw/rtl/wvalu_pkg.sv */
// Types, opcodes and shared arithmetic helpers for the width-aware integer ALU.
package wvalu_pkg;

  localparam int XLEN = 64;
  localparam int HALF = 32;

  typedef logic [XLEN-1:0] word_t;
  typedef logic [6:0]      width_t;
  typedef logic [4:0]      opcode_t;

  localparam width_t FULL_WIDTH = 7'd64;

  localparam opcode_t OP_ADD   = 5'd0;
  localparam opcode_t OP_SUB   = 5'd1;
  localparam opcode_t OP_MUL   = 5'd2;
  localparam opcode_t OP_DIV   = 5'd3;
  localparam opcode_t OP_MOD   = 5'd4;
  localparam opcode_t OP_POW   = 5'd5;
  localparam opcode_t OP_AND   = 5'd6;
  localparam opcode_t OP_OR    = 5'd7;
  localparam opcode_t OP_XOR   = 5'd8;
  localparam opcode_t OP_XNOR  = 5'd9;
  localparam opcode_t OP_SHL   = 5'd10;
  localparam opcode_t OP_LSHR  = 5'd11;
  localparam opcode_t OP_ASHR  = 5'd12;
  localparam opcode_t OP_LT    = 5'd13;
  localparam opcode_t OP_GT    = 5'd14;
  localparam opcode_t OP_LE    = 5'd15;
  localparam opcode_t OP_GE    = 5'd16;
  localparam opcode_t OP_EQ    = 5'd17;
  localparam opcode_t OP_NE    = 5'd18;
  localparam opcode_t OP_LAND  = 5'd19;
  localparam opcode_t OP_LOR   = 5'd20;
  localparam opcode_t OP_IMPL  = 5'd21;
  localparam opcode_t OP_EQUIV = 5'd22;
  localparam opcode_t OP_NEG   = 5'd23;
  localparam opcode_t OP_PLUS  = 5'd24;
  localparam opcode_t OP_NOT   = 5'd25;
  localparam opcode_t OP_LNOT  = 5'd26;

  // Operands after width and sign normalization.
  typedef struct packed {
    opcode_t op;
    word_t   lv;
    word_t   rv;
    word_t   amt;
    width_t  w;
    logic    s;
  } dec_t;

  // Partial products of a 64-bit low-half multiply.
  typedef struct packed {
    word_t             lo;
    logic [HALF-1:0]   c1;
    logic [HALF-1:0]   c2;
  } pp_t;

  typedef struct packed {
    logic    start;
    logic    ack;
    opcode_t op;
    logic    s;
  } iter_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic err;
  } iter_sts_t;

  function automatic word_t mask_of(width_t w);
    return {XLEN{1'b1}} >> (FULL_WIDTH - w);
  endfunction

  function automatic word_t sext_of(word_t v, width_t w);
    word_t      m;
    logic [5:0] msb;
    m   = mask_of(w);
    msb = 6'(w - 7'd1);
    return v[msb] ? ((v & m) | ~m) : (v & m);
  endfunction

  function automatic pp_t mul_pp(word_t x, word_t y);
    pp_t   p;
    word_t h1;
    word_t h2;
    p.lo = x[HALF-1:0] * y[HALF-1:0];
    h1   = x[HALF-1:0] * y[XLEN-1:HALF];
    h2   = x[XLEN-1:HALF] * y[HALF-1:0];
    p.c1 = h1[HALF-1:0];
    p.c2 = h2[HALF-1:0];
    return p;
  endfunction

  function automatic word_t mul_sum(pp_t p);
    return p.lo + {p.c1 + p.c2, {HALF{1'b0}}};
  endfunction

endpackage

/* hw/rtl/width_aware_verilog_integer_alu.sv */
// Width-aware integer ALU top level: four-stage pipeline plus divide/power unit.
// Items flow decode -> execute -> combine -> output register. Add, subtract,
// multiply, logic, shift, compare and unary operations enter one per cycle
// while the output is not stalled. Multiply splits into 32-bit partial
// products in the execute stage and sums them in the combine stage. Divide
// and modulo hold the decode stage in the one-bit-per-cycle divider and its
// sign fix-up; power holds it for a multiply, accumulate and square step per
// exponent bit up to the highest set bit (zero or negative exponents, or
// division by zero, take no iteration), and input is stalled meanwhile. Both
// channels stall freely without loss.
module width_aware_verilog_integer_alu #(
  parameter int DATA_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         opcode,
  input  logic signed [63:0] left_value,
  input  logic [6:0]         left_width,
  input  logic               left_signed,
  input  logic signed [63:0] right_value,
  input  logic [6:0]         right_width,
  input  logic               right_signed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] result_value,
  output logic [6:0]         result_width,
  output logic               result_signed,
  output logic               error
);

  localparam wvalu_pkg::width_t MAX_WIDTH = 7'(DATA_BITS);

  wvalu_pkg::dec_t      dec_in;
  wvalu_pkg::dec_t      s1;
  logic                 s1_valid;
  logic                 iter_op1;
  logic                 go1;
  logic                 rdy1;
  logic                 rdy2;
  logic                 rdy3;
  logic                 rdy_o;
  wvalu_pkg::iter_ctl_t it_ctl;
  wvalu_pkg::iter_sts_t it_sts;
  wvalu_pkg::word_t     it_result;

  logic                 big;
  logic [5:0]           sh;
  logic                 lt;
  logic                 gt;
  logic signed [63:0]   asr;
  wvalu_pkg::word_t     ex_r;
  logic                 ex_err;

  logic                 s2_valid;
  wvalu_pkg::word_t     s2_r;
  wvalu_pkg::pp_t       s2_pp;
  logic                 s2_mul;
  logic                 s2_err;
  logic                 s2_noext;
  wvalu_pkg::width_t    s2_w;
  logic                 s2_s;

  logic                 s3_valid;
  wvalu_pkg::word_t     s3_r;
  logic                 s3_err;
  logic                 s3_noext;
  wvalu_pkg::width_t    s3_w;
  logic                 s3_s;
  wvalu_pkg::word_t     fmt;

  wvalu_decode u_decode (
    .op           (opcode),
    .left_value   (left_value),
    .left_width   (left_width),
    .left_signed  (left_signed),
    .right_value  (right_value),
    .right_width  (right_width),
    .right_signed (right_signed),
    .max_width    (MAX_WIDTH),
    .dec          (dec_in)
  );

  assign iter_op1 = (s1.op == wvalu_pkg::OP_DIV) || (s1.op == wvalu_pkg::OP_MOD) ||
                    (s1.op == wvalu_pkg::OP_POW);

  // ready chain, back from the output register
  assign rdy_o    = !out_valid || !out_stall;
  assign rdy3     = !s3_valid || rdy_o;
  assign rdy2     = !s2_valid || rdy3;
  assign go1      = s1_valid && (!iter_op1 || it_sts.done) && rdy2;
  assign rdy1     = !s1_valid || go1;
  assign in_stall = !rdy1;

  assign it_ctl.start = s1_valid && iter_op1 && !it_sts.busy && !it_sts.done;
  assign it_ctl.ack   = go1;
  assign it_ctl.op    = s1.op;
  assign it_ctl.s     = s1.s;

  wvalu_iter u_iter (
    .clk    (clk),
    .rst    (rst),
    .ctl    (it_ctl),
    .lv     (s1.lv),
    .rv     (s1.rv),
    .sts    (it_sts),
    .result (it_result)
  );

  // stage 1: normalized operands
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rdy1) begin
      s1_valid <= in_valid;
    end
    if (in_valid && rdy1) begin
      s1 <= dec_in;
    end
  end

  // execute
  always_comb begin
    big    = |s1.amt[63:6];
    sh     = s1.amt[5:0];
    lt     = s1.s ? ($signed(s1.lv) < $signed(s1.rv)) : (s1.lv < s1.rv);
    gt     = s1.s ? ($signed(s1.rv) < $signed(s1.lv)) : (s1.rv < s1.lv);
    asr    = $signed(s1.lv) >>> sh;
    ex_r   = '0;
    ex_err = 1'b0;
    case (s1.op)
      wvalu_pkg::OP_ADD:   ex_r = s1.lv + s1.rv;
      wvalu_pkg::OP_SUB:   ex_r = s1.lv - s1.rv;
      wvalu_pkg::OP_MUL:   ex_r = '0;
      wvalu_pkg::OP_DIV,
      wvalu_pkg::OP_MOD,
      wvalu_pkg::OP_POW: begin
        ex_r   = it_result;
        ex_err = it_sts.err;
      end
      wvalu_pkg::OP_AND:   ex_r = s1.lv & s1.rv;
      wvalu_pkg::OP_OR:    ex_r = s1.lv | s1.rv;
      wvalu_pkg::OP_XOR:   ex_r = s1.lv ^ s1.rv;
      wvalu_pkg::OP_XNOR:  ex_r = ~(s1.lv ^ s1.rv);
      wvalu_pkg::OP_SHL:   ex_r = big ? '0 : (s1.lv << sh);
      wvalu_pkg::OP_LSHR:  ex_r = big ? '0 : ((s1.lv & wvalu_pkg::mask_of(s1.w)) >> sh);
      wvalu_pkg::OP_ASHR: begin
        if (s1.s) begin
          ex_r = big ? {wvalu_pkg::XLEN{s1.lv[63]}} : wvalu_pkg::word_t'(asr);
        end else begin
          ex_r = big ? '0 : (s1.lv >> sh);
        end
      end
      wvalu_pkg::OP_LT:    ex_r = wvalu_pkg::word_t'(lt);
      wvalu_pkg::OP_GT:    ex_r = wvalu_pkg::word_t'(gt);
      wvalu_pkg::OP_LE:    ex_r = wvalu_pkg::word_t'(!gt);
      wvalu_pkg::OP_GE:    ex_r = wvalu_pkg::word_t'(!lt);
      wvalu_pkg::OP_EQ:    ex_r = wvalu_pkg::word_t'(s1.lv == s1.rv);
      wvalu_pkg::OP_NE:    ex_r = wvalu_pkg::word_t'(s1.lv != s1.rv);
      wvalu_pkg::OP_LAND:  ex_r = wvalu_pkg::word_t'((s1.lv != '0) && (s1.rv != '0));
      wvalu_pkg::OP_LOR:   ex_r = wvalu_pkg::word_t'((s1.lv != '0) || (s1.rv != '0));
      wvalu_pkg::OP_IMPL:  ex_r = wvalu_pkg::word_t'((s1.lv == '0) || (s1.rv != '0));
      wvalu_pkg::OP_EQUIV: ex_r = wvalu_pkg::word_t'((s1.lv != '0) == (s1.rv != '0));
      wvalu_pkg::OP_NEG:   ex_r = wvalu_pkg::word_t'(0) - s1.lv;
      wvalu_pkg::OP_PLUS:  ex_r = s1.lv;
      wvalu_pkg::OP_NOT:   ex_r = ~s1.lv;
      wvalu_pkg::OP_LNOT:  ex_r = wvalu_pkg::word_t'(s1.lv == '0);
      default:             ex_err = 1'b1;
    endcase
  end

  // stage 2: execute results and multiply partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (rdy2) begin
      s2_valid <= go1;
    end
    if (go1) begin
      s2_r     <= ex_r;
      s2_pp    <= wvalu_pkg::mul_pp(s1.lv, s1.rv);
      s2_mul   <= (s1.op == wvalu_pkg::OP_MUL);
      s2_err   <= ex_err;
      s2_noext <= (s1.op == wvalu_pkg::OP_LSHR);
      s2_w     <= s1.w;
      s2_s     <= s1.s;
    end
  end

  // stage 3: combine partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (rdy3) begin
      s3_valid <= s2_valid;
    end
    if (s2_valid && rdy3) begin
      s3_r     <= s2_mul ? wvalu_pkg::mul_sum(s2_pp) : s2_r;
      s3_err   <= s2_err;
      s3_noext <= s2_noext;
      s3_w     <= s2_w;
      s3_s     <= s2_s;
    end
  end

  always_comb begin
    fmt = s3_r & wvalu_pkg::mask_of(s3_w);
    if (s3_s && !s3_noext) begin
      fmt = wvalu_pkg::sext_of(s3_r, s3_w);
    end
    if (s3_err) begin
      fmt = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_o) begin
      out_valid <= s3_valid;
    end
    if (s3_valid && rdy_o) begin
      result_value  <= fmt;
      result_width  <= s3_w;
      result_signed <= s3_s;
      error         <= s3_err;
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> result_value == '0)
    else $error("error transaction carries a nonzero value");

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result_width != '0) && (result_width <= MAX_WIDTH))
    else $error("result width out of range");

  a_unsigned_upper: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_signed |->
      (result_value & ~wvalu_pkg::mask_of(result_width)) == '0)
    else $error("unsigned result has bits above its width");

  a_iter_hold: assert property (@(posedge clk) disable iff (rst)
    it_sts.busy |-> s1_valid && iter_op1 && in_stall)
    else $error("divide/power unit busy without a held transaction");

  a_iter_done: assert property (@(posedge clk) disable iff (rst)
    it_sts.done |-> s1_valid && iter_op1)
    else $error("divide/power result with no transaction waiting");
`endif

endmodule

/* hw/rtl/wvalu_decode.sv */
// Operand normalization: width clamp, result type, sign extension or truncation.
module wvalu_decode (
  input  wvalu_pkg::opcode_t op,
  input  wvalu_pkg::word_t   left_value,
  input  wvalu_pkg::width_t  left_width,
  input  logic               left_signed,
  input  wvalu_pkg::word_t   right_value,
  input  wvalu_pkg::width_t  right_width,
  input  logic               right_signed,
  input  wvalu_pkg::width_t  max_width,
  output wvalu_pkg::dec_t    dec
);

  wvalu_pkg::width_t lw;
  wvalu_pkg::width_t rw;
  logic              unary;

  always_comb begin
    lw = (left_width == '0 || left_width > max_width) ? max_width : left_width;
    rw = (right_width == '0 || right_width > max_width) ? max_width : right_width;
    unary = (op >= wvalu_pkg::OP_NEG) && (op <= wvalu_pkg::OP_LNOT);
    dec.op  = op;
    dec.w   = unary ? lw : ((lw > rw) ? lw : rw);
    dec.s   = unary ? left_signed : (left_signed & right_signed);
    dec.lv  = dec.s ? wvalu_pkg::sext_of(left_value, lw)
                    : (left_value & wvalu_pkg::mask_of(lw));
    dec.rv  = dec.s ? wvalu_pkg::sext_of(right_value, rw)
                    : (right_value & wvalu_pkg::mask_of(rw));
    // shift amount is always the right operand read as unsigned
    dec.amt = right_value & wvalu_pkg::mask_of(rw);
  end

endmodule

/* hw/rtl/wvalu_iter.sv */
// Multi-cycle unit for division, modulo and power.
module wvalu_iter (
  input  logic                 clk,
  input  logic                 rst,
  input  wvalu_pkg::iter_ctl_t ctl,
  input  wvalu_pkg::word_t     lv,
  input  wvalu_pkg::word_t     rv,
  output wvalu_pkg::iter_sts_t sts,
  output wvalu_pkg::word_t     result
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_DFIX = 3'd2;
  localparam logic [2:0] ST_POW  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [1:0] PH_MUL = 2'd0;
  localparam logic [1:0] PH_ACC = 2'd1;
  localparam logic [1:0] PH_SQR = 2'd2;

  logic [2:0]       state;
  logic [1:0]       phase;
  logic [5:0]       cnt;
  logic             err;
  logic             neg_a;
  logic             neg_b;
  logic             mod_sel;
  wvalu_pkg::word_t res;
  wvalu_pkg::word_t quo;
  wvalu_pkg::word_t rem;
  wvalu_pkg::word_t dvs;
  wvalu_pkg::word_t acc;
  wvalu_pkg::word_t base;
  wvalu_pkg::word_t expo;
  wvalu_pkg::pp_t   pp;
  logic [64:0]      rem_sh;
  logic [64:0]      diff;

  always_comb begin
    rem_sh = {rem, quo[63]};
    diff   = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (ctl.start) begin
            err <= 1'b0;
            res <= '0;
            if (ctl.op == wvalu_pkg::OP_POW) begin
              if (ctl.s && rv[63]) begin
                // negative exponent: only bases 1 and -1 survive
                state <= ST_DONE;
                if (lv == '0) begin
                  err <= 1'b1;
                end else if (lv == 64'd1) begin
                  res <= 64'd1;
                end else if (lv == '1) begin
                  res <= rv[0] ? '1 : 64'd1;
                end
              end else if (rv == '0) begin
                res   <= 64'd1;
                state <= ST_DONE;
              end else begin
                acc   <= 64'd1;
                base  <= lv;
                expo  <= rv;
                phase <= PH_MUL;
                state <= ST_POW;
              end
            end else if (rv == '0) begin
              err   <= 1'b1;
              state <= ST_DONE;
            end else begin
              neg_a   <= ctl.s & lv[63];
              neg_b   <= ctl.s & rv[63];
              quo     <= (ctl.s & lv[63]) ? (wvalu_pkg::word_t'(0) - lv) : lv;
              dvs     <= (ctl.s & rv[63]) ? (wvalu_pkg::word_t'(0) - rv) : rv;
              rem     <= '0;
              cnt     <= '0;
              mod_sel <= (ctl.op == wvalu_pkg::OP_MOD);
              state   <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (!diff[64]) begin
            rem <= diff[63:0];
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh[63:0];
            quo <= {quo[62:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= ST_DFIX;
          end
        end
        ST_DFIX: begin
          if (mod_sel) begin
            res <= neg_a ? (wvalu_pkg::word_t'(0) - rem) : rem;
          end else begin
            res <= (neg_a ^ neg_b) ? (wvalu_pkg::word_t'(0) - quo) : quo;
          end
          state <= ST_DONE;
        end
        ST_POW: begin
          case (phase)
            PH_MUL: begin
              pp    <= wvalu_pkg::mul_pp(acc, base);
              phase <= PH_ACC;
            end
            PH_ACC: begin
              if (expo[0]) begin
                acc <= wvalu_pkg::mul_sum(pp);
              end
              pp    <= wvalu_pkg::mul_pp(base, base);
              phase <= PH_SQR;
            end
            default: begin
              base  <= wvalu_pkg::mul_sum(pp);
              expo  <= expo >> 1;
              phase <= PH_MUL;
              if (expo[63:1] == '0) begin
                res   <= acc;
                state <= ST_DONE;
              end
            end
          endcase
        end
        ST_DONE: begin
          if (ctl.ack) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    sts.busy = (state != ST_IDLE) && (state != ST_DONE);
    sts.done = (state == ST_DONE);
    sts.err  = err;
    result   = res;
  end

endmodule

/* dv/width_aware_verilog_integer_alu_test.sv */
// Self-checking testbench for the width-aware integer ALU.
`timescale 1ns / 100ps

module width_aware_verilog_integer_alu_test;

  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [63:0] value;
    logic [6:0]  width;
    logic        sgn;
    logic        err;
  } alu_answer_t;

  class alu_scoreboard;
    alu_answer_t pending[$];
    int          mismatches;
    int          checked;

    function logic [63:0] wmask(int w);
      return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    function logic [63:0] sx(logic [63:0] v, int w);
      logic [63:0] m;
      m = wmask(w);
      v = v & m;
      if (w < 64 && v[w-1]) v = v | ~m;
      return v;
    endfunction

    function int clampw(logic [6:0] w);
      return (w == 0 || w > 64) ? 64 : int'(w);
    endfunction

    function logic [63:0] upow(logic [63:0] b, logic [63:0] e);
      logic [63:0] r;
      r = 1;
      while (e != 0) begin
        if (e[0]) r = r * b;
        b = b * b;
        e = e >> 1;
      end
      return r;
    endfunction

    // Compute the answer for one transaction and queue it.
    function void note_operation(logic [4:0] op, logic [63:0] lraw, logic [6:0] lwi,
                                 logic ls, logic [63:0] rraw, logic [6:0] rwi, logic rs);
      alu_answer_t a;
      int          lw;
      int          rw;
      int          w;
      logic        s;
      logic        err;
      logic        no_ext;
      logic        lt;
      logic        gt;
      logic        na;
      logic        nb;
      logic [63:0] lv;
      logic [63:0] rv;
      logic [63:0] r;
      logic [63:0] amt;
      logic [63:0] ua;
      logic [63:0] ub;
      lw = clampw(lwi);
      rw = clampw(rwi);
      err = 0;
      no_ext = 0;
      r = 0;
      if (op >= wvalu_pkg::OP_NEG && op <= wvalu_pkg::OP_LNOT) begin
        w = lw;
        s = ls;
        lv = s ? sx(lraw, w) : (lraw & wmask(w));
        case (op)
          wvalu_pkg::OP_NEG:  r = -lv;
          wvalu_pkg::OP_PLUS: r = lv;
          wvalu_pkg::OP_NOT:  r = ~lv;
          default: r = (lv == 0);
        endcase
      end else begin
        w = (lw > rw) ? lw : rw;
        s = ls && rs;
        lv = s ? sx(lraw, lw) : (lraw & wmask(lw));
        rv = s ? sx(rraw, rw) : (rraw & wmask(rw));
        amt = rraw & wmask(rw);
        lt = s ? ($signed(lv) < $signed(rv)) : (lv < rv);
        gt = s ? ($signed(rv) < $signed(lv)) : (rv < lv);
        case (op)
          wvalu_pkg::OP_ADD: r = lv + rv;
          wvalu_pkg::OP_SUB: r = lv - rv;
          wvalu_pkg::OP_MUL: r = lv * rv;
          wvalu_pkg::OP_DIV, wvalu_pkg::OP_MOD: begin
            if (rv == 0) err = 1;
            else if (!s) r = (op == wvalu_pkg::OP_DIV) ? lv / rv : lv % rv;
            else begin
              na = lv[63];
              nb = rv[63];
              ua = na ? -lv : lv;
              ub = nb ? -rv : rv;
              if (op == wvalu_pkg::OP_DIV) begin
                r = ua / ub;
                if (na != nb) r = -r;
              end else begin
                r = ua % ub;
                if (na) r = -r;
              end
            end
          end
          wvalu_pkg::OP_POW: begin
            if (s && rv[63]) begin
              if (lv == 0) err = 1;
              else if (lv == 1) r = 1;
              else if (lv == '1) r = rv[0] ? '1 : 64'd1;
              else r = 0;
            end else r = upow(lv, rv);
          end
          wvalu_pkg::OP_AND:  r = lv & rv;
          wvalu_pkg::OP_OR:   r = lv | rv;
          wvalu_pkg::OP_XOR:  r = lv ^ rv;
          wvalu_pkg::OP_XNOR: r = ~(lv ^ rv);
          wvalu_pkg::OP_SHL:  r = (amt >= 64) ? 64'd0 : (lv << amt);
          wvalu_pkg::OP_LSHR: begin
            r = (amt >= 64) ? 64'd0 : ((lv & wmask(w)) >> amt);
            no_ext = 1;
          end
          wvalu_pkg::OP_ASHR: begin
            if (s) r = (amt >= 64) ? {64{lv[63]}} : 64'($signed(lv) >>> amt);
            else r = (amt >= 64) ? 64'd0 : (lv >> amt);
          end
          wvalu_pkg::OP_LT:    r = lt;
          wvalu_pkg::OP_GT:    r = gt;
          wvalu_pkg::OP_LE:    r = !gt;
          wvalu_pkg::OP_GE:    r = !lt;
          wvalu_pkg::OP_EQ:    r = (lv == rv);
          wvalu_pkg::OP_NE:    r = (lv != rv);
          wvalu_pkg::OP_LAND:  r = (lv != 0 && rv != 0);
          wvalu_pkg::OP_LOR:   r = (lv != 0 || rv != 0);
          wvalu_pkg::OP_IMPL:  r = (lv == 0 || rv != 0);
          wvalu_pkg::OP_EQUIV: r = ((lv != 0) == (rv != 0));
          default:  err = 1;
        endcase
      end
      a.value = 0;
      if (!err) begin
        a.value = r & wmask(w);
        if (s && !no_ext) a.value = sx(a.value, w);
      end
      a.width = 7'(w);
      a.sgn = s;
      a.err = err;
      pending.push_back(a);
    endfunction

    function void check_result(logic [63:0] v, logic [6:0] w, logic sg, logic e);
      alu_answer_t x;
      if (pending.size() == 0) begin
        $error("unexpected result value=%h", v);
        mismatches++;
        return;
      end
      x = pending.pop_front();
      checked++;
      if (v !== x.value) begin
        $error("result_value exp %h got %h", x.value, v);
        mismatches++;
      end
      if (w !== x.width) begin
        $error("result_width exp %0d got %0d", x.width, w);
        mismatches++;
      end
      if (sg !== x.sgn) begin
        $error("result_signed exp %b got %b", x.sgn, sg);
        mismatches++;
      end
      if (e !== x.err) begin
        $error("error exp %b got %b", x.err, e);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [4:0]  opcode;
  logic [63:0] left_value;
  logic [6:0]  left_width;
  logic        left_signed;
  logic [63:0] right_value;
  logic [6:0]  right_width;
  logic        right_signed;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] result_value;
  logic [6:0]  result_width;
  logic        result_signed;
  logic        error;

  alu_scoreboard board;
  bit            calm;
  bit            hold_results;
  bit            sent_all;
  int            idle_cycles;
  int            sent;

  width_aware_verilog_integer_alu u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .left_value(left_value), .left_width(left_width),
    .left_signed(left_signed), .right_value(right_value),
    .right_width(right_width), .right_signed(right_signed),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .result_width(result_width),
    .result_signed(result_signed), .error(error)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function logic [63:0] rand_word();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = '1;
      2: v = 64'($urandom_range(0, 5));
      3: v = {1'b1, 63'd0};
      4: v = -64'($urandom_range(1, 3));
      default: ;
    endcase
    return v;
  endfunction

  function logic [6:0] rand_width();
    case ($urandom_range(0, 5))
      0: return 7'd64;
      1: return 7'd1;
      2: return 7'($urandom_range(0, 127));
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  // Offer one transaction and hold it until accepted; valid stays high after.
  task automatic send_op(logic [4:0] op, logic [63:0] lv, logic [6:0] lw, logic ls,
                         logic [63:0] rv, logic [6:0] rw, logic rs);
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    opcode <= op;
    left_value <= lv;
    left_width <= lw;
    left_signed <= ls;
    right_value <= rv;
    right_width <= rw;
    right_signed <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_operation(op, lv, lw, ls, rv, rw, rs);
    sent++;
  endtask

  // Keep the power exponent small in width most of the time.
  task automatic send_random();
    logic [4:0]  op;
    logic [63:0] rv;
    logic [6:0]  rw;
    op = 5'($urandom_range(0, 31));
    if (op > 26 && $urandom_range(0, 3) != 0) op = 5'($urandom_range(0, 26));
    rv = rand_word();
    rw = rand_width();
    if (op == wvalu_pkg::OP_POW && $urandom_range(0, 3) != 0) begin
      rw = 7'($urandom_range(1, 8));
    end
    send_op(op, rand_word(), rand_width(), 1'($urandom), rv, rw, 1'($urandom));
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else out_stall <= hold_results || (!calm && $urandom_range(0, 99) < 19);
    if (!rst && out_valid && !out_stall)
      board.check_result(result_value, result_width, result_signed, error);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    board = new();
    rst = 1;
    in_valid = 0;
    out_stall = 0;
    opcode = 0;
    left_value = 0;
    left_width = 1;
    left_signed = 0;
    right_value = 0;
    right_width = 1;
    right_signed = 0;
    calm = 0;
    hold_results = 0;
    sent_all = 0;
    idle_cycles = 0;
    sent = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed corners: every opcode, extreme widths, modulo by zero, min / -1.
    for (int k = 0; k <= 27; k++)
      send_op(5'(k), 64'hFFFF_FFFF_FFFF_FFF5, 7'd64, k[0], 64'd3, 7'd8, 1'b1);
    send_op(wvalu_pkg::OP_DIV, {1'b1, 63'd0}, 7'd64, 1, '1, 7'd64, 1);
    send_op(wvalu_pkg::OP_MOD, 64'd7, 7'd4, 0, 64'd0, 7'd4, 0);
    send_op(wvalu_pkg::OP_POW, 64'd0, 7'd8, 1, '1, 7'd8, 1);
    send_op(wvalu_pkg::OP_POW, '1, 7'd8, 1, -64'd3, 7'd8, 1);
    send_op(wvalu_pkg::OP_ASHR, {1'b1, 63'd0}, 7'd64, 1, 64'd100, 7'd7, 1);
    send_op(wvalu_pkg::OP_LSHR, 64'h80, 7'd8, 1, 64'd1, 7'd4, 1);
    send_op(wvalu_pkg::OP_LT, 64'd0, 7'd0, 1, 64'd1, 7'd127, 1);
    send_op(wvalu_pkg::OP_EQ, 64'd1, 7'd1, 1, 64'd1, 7'd1, 1);
    in_valid <= 0;
    // Drain completely before the back-pressure phase.
    while (board.pending.size() != 0) @(posedge clk);
    // Hold the output off long enough for the pipeline to back up.
    fork
      begin
        hold_results = 1;
        repeat (60) @(posedge clk);
        hold_results = 0;
      end
      begin
        for (int k = 0; k < 12; k++)
          send_op(wvalu_pkg::OP_ADD, rand_word(), 7'd64, 1, rand_word(), 7'd64, 1);
        in_valid <= 0;
        @(posedge clk);
      end
    join
    for (int k = 0; k < 700; k++) begin
      calm = (k >= 200 && k < 320);
      send_random();
    end
    in_valid <= 0;
    calm = 0;
    sent_all = 1;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("run: %0d operations sent, %0d results checked, all opcodes and width corners",
             sent, board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

/* sim.f */
hw/rtl/wvalu_pkg.sv
hw/rtl/wvalu_decode.sv
hw/rtl/wvalu_iter.sv
hw/rtl/width_aware_verilog_integer_alu.sv
dv/width_aware_verilog_integer_alu_test.sv
